// ===== hdl/tsdr_pkg.sv =====
// Shared types and constants for the text screen diff refresher.
// No dependencies; tsdr_cfg, tsdr_ctrl and the top level import this package.
package tsdr_pkg;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [7:0] WIDTH_RST  = 8'd80;
	localparam logic [6:0] HEIGHT_RST = 7'd25;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_IGN_BG = 2'd2;

	localparam logic [7:0] GLYPH_SPACE = 8'd32;
	localparam logic [7:0] MASK_FG     = 8'h0F;
	localparam logic [7:0] MASK_ALL    = 8'hFF;

	// result slots of one scan, in emission order
	localparam int SLOTS  = 5;
	localparam int SLOT_W = 3;
	localparam logic [SLOT_W-1:0] SLOT_FRAME  = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_ROW    = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_SKIP   = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_COLOUR = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_GLYPH  = 3'd4;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_INVAL = 2'd2,
		MODE_SCAN  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CMD_MOVE       = 3'd0,
		CMD_FORE3      = 3'd1,
		CMD_HL_BACK    = 3'd2,
		CMD_FORE_BACK  = 3'd3,
		CMD_BACK       = 3'd4,
		CMD_FORE3_BACK = 3'd5,
		CMD_GLYPH      = 3'd6,
		CMD_REFRESH    = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_PREP,
		ST_CLAMP,
		ST_DIV,
		ST_READ,
		ST_EMIT,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic [7:0] width;
		logic [6:0] height;
		logic       ign_bg;
		logic       upd;
	} cfg_t;

endpackage

// ===== hdl/tsdr_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
// Uses no package; instanced twice (current and shown cell stores).
module tsdr_ram #(
	parameter int DEPTH = 8192,
	parameter int DATA_W = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/tsdr_cfg.sv =====
// APB register file: screen width, screen height, ignore-background flag.
// Depends on tsdr_pkg for register indexes and the cfg_t bundle.
module tsdr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsdr_pkg::PADDR_W-1:0]  paddr,
	input  logic [tsdr_pkg::PDATA_W-1:0]  pwdata,
	output logic [tsdr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output tsdr_pkg::cfg_t                cfg
);

	import tsdr_pkg::*;

	logic [7:0] width_q;
	logic [6:0] height_q;
	logic       ign_bg_q;
	logic       wr;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			ign_bg_q <= 1'b0;
		end else if (wr) begin
			case (idx)
				REG_WIDTH:  width_q  <= pwdata[7:0];
				REG_HEIGHT: height_q <= pwdata[6:0];
				REG_IGN_BG: ign_bg_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = {24'd0, width_q};
			REG_HEIGHT: prdata = {25'd0, height_q};
			REG_IGN_BG: prdata = {31'd0, ign_bg_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.width  = width_q;
	assign cfg.height = height_q;
	assign cfg.ign_bg = ign_bg_q;
	assign cfg.upd    = wr;

endmodule

// ===== hdl/tsdr_ctrl.sv =====
// Sequencer: cell writes, clearing sweeps, scan read-modify-write and result beats.
// Depends on tsdr_pkg; drives the ports of the two tsdr_ram stores.
module tsdr_ctrl #(
	parameter int CELL_COUNT = 8192,
	localparam int POS_W = $clog2(CELL_COUNT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           mode,
	input  logic [6:0]           col,
	input  logic [5:0]           row,
	input  logic [7:0]           glyph,
	input  logic [7:0]           attribute,
	input  tsdr_pkg::cfg_t       cfg,
	output logic                 cur_we,
	output logic [POS_W-1:0]     cur_waddr,
	output logic [15:0]          cur_wdata,
	output logic                 old_we,
	output logic [POS_W-1:0]     old_waddr,
	output logic [15:0]          old_wdata,
	output logic                 rd_en,
	output logic [POS_W-1:0]     rd_addr,
	input  logic [15:0]          cur_rdata,
	input  logic [15:0]          old_rdata,
	output logic                 strobe,
	output logic [2:0]           command,
	output logic [6:0]           cursor_col,
	output logic [5:0]           cursor_row,
	output logic [3:0]           fore,
	output logic [3:0]           back,
	output logic [7:0]           out_glyph,
	output logic                 last
);

	import tsdr_pkg::*;

	localparam int CNT_W = POS_W + 1;
	localparam int DIV_W = $clog2(POS_W);
	localparam int COL_W = 8;
	localparam int ROW_W = 7;

	state_t state_q, state_d;
	mode_t  in_mode;
	logic   accept;
	logic   stale_eff;

	logic [POS_W-1:0] pos_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CNT_W-1:0] cells_q;
	logic             stale_q;
	logic [7:0]       last_colour_q;
	logic             in_run_q;

	logic [COL_W-1:0] rem_q;
	logic [POS_W-1:0] quo_q;
	logic [DIV_W-1:0] div_cnt_q;
	logic [POS_W-1:0] clr_q;
	logic             clr_old_q;

	logic [6:0] wr_col_q;
	logic [5:0] wr_row_q;
	logic [7:0] wr_glyph_q;
	logic [7:0] wr_attr_q;

	logic [SLOTS-1:0] mask_q;
	logic [7:0]       sl_lc_q;
	logic [7:0]       sl_attr_q;
	logic [7:0]       sl_glyph_q;
	logic [COL_W-1:0] sl_col_q;
	logic [ROW_W-1:0] sl_row_q;
	logic             sl_final_q;
	cmd_t             sl_ccmd_q;

	logic       strobe_q;
	cmd_t       command_q;
	logic [6:0] cursor_col_q;
	logic [5:0] cursor_row_q;
	logic [3:0] fore_q;
	logic [3:0] back_q;
	logic [7:0] out_glyph_q;
	logic       last_q;

	logic [7:0]       w_eff;
	logic [6:0]       h_eff;
	logic [14:0]      prod;
	logic [CNT_W-1:0] cells_c;
	logic [POS_W-1:0] pos_cl;
	logic [13:0]      wr_off;
	logic             wr_ok;
	logic             div_done;
	logic [8:0]       trial;
	logic             ge;
	logic [COL_W-1:0] rem_nx;
	logic [POS_W-1:0] quo_nx;

	logic [7:0]       amask;
	logic [7:0]       attr;
	logic [7:0]       oattr;
	logic             first;
	logic             final_c;
	logic [7:0]       lc_eff;
	logic             run_eff;
	logic             changed;
	logic [7:0]       diff;
	logic             colour_on;
	cmd_t             ccmd;
	logic [SLOTS-1:0] mask_c;
	logic [COL_W-1:0] col_inc;

	logic [SLOT_W-1:0] sel;
	logic [SLOTS-1:0]  mask_left;

	cmd_t       beat_cmd;
	logic [6:0] beat_col;
	logic [5:0] beat_row;
	logic [7:0] beat_colour;
	logic [7:0] beat_glyph;

	assign in_mode   = mode_t'(mode);
	assign accept    = start & ~busy;
	assign stale_eff = stale_q | cfg.upd;

	assign w_eff = (cfg.width == 8'd0) ? 8'd1 : cfg.width;
	assign h_eff = (cfg.height == 7'd0) ? 7'd1 : cfg.height;
	assign prod  = 15'(w_eff) * 15'(h_eff);
	assign cells_c = (32'(prod) >= 32'(CELL_COUNT)) ? CNT_W'(CELL_COUNT) : CNT_W'(prod);
	assign pos_cl  = ({1'b0, pos_q} >= cells_q) ? POS_W'(cells_q - CNT_W'(1)) : pos_q;

	assign wr_off = 14'(wr_row_q) * 14'(w_eff) + 14'(wr_col_q);
	assign wr_ok  = ({1'b0, wr_col_q} < w_eff) && ({1'b0, wr_row_q} < h_eff)
		&& (32'(wr_off) < 32'(CELL_COUNT));

	// restoring divide of the scan position by the width, one quotient bit a cycle
	assign div_done = (div_cnt_q == DIV_W'(POS_W - 1));
	assign trial    = {rem_q, quo_q[POS_W-1]};
	assign ge       = (trial >= {1'b0, w_eff});
	assign rem_nx   = ge ? COL_W'(trial - {1'b0, w_eff}) : COL_W'(trial);
	assign quo_nx   = {quo_q[POS_W-2:0], ge};

	// scan evaluation on the data returned by the stores
	assign amask   = cfg.ign_bg ? MASK_FG : MASK_ALL;
	assign attr    = cur_rdata[7:0] & amask;
	assign oattr   = old_rdata[7:0] & amask;
	assign first   = (pos_q == '0);
	assign final_c = ({1'b0, pos_q} == cells_q - CNT_W'(1));
	assign lc_eff  = first ? attr : last_colour_q;
	assign run_eff = first | in_run_q;
	assign changed = (cur_rdata[15:8] != old_rdata[15:8]) || (attr != oattr);
	assign diff    = lc_eff ^ attr;
	assign col_inc = col_q + COL_W'(1);

	always_comb begin
		colour_on = 1'b1;
		case ({|diff[6:4], diff[3], |diff[2:0]})
			3'b000: begin
				colour_on = 1'b0;
				ccmd      = CMD_FORE3;
			end
			3'b001:         ccmd = CMD_FORE3;
			3'b010, 3'b110: ccmd = attr[3] ? CMD_HL_BACK : CMD_FORE_BACK;
			3'b011, 3'b111: ccmd = CMD_FORE_BACK;
			3'b100:         ccmd = CMD_BACK;
			default:        ccmd = CMD_FORE3_BACK;
		endcase
	end

	always_comb begin
		mask_c              = '0;
		mask_c[SLOT_FRAME]  = first;
		mask_c[SLOT_ROW]    = (col_q == '0);
		mask_c[SLOT_SKIP]   = final_c | (changed & ~run_eff);
		mask_c[SLOT_COLOUR] = ~final_c & changed & colour_on;
		mask_c[SLOT_GLYPH]  = ~final_c & changed;
	end

	always_comb begin
		sel = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) sel = SLOT_W'(i);
		end
		mask_left      = mask_q;
		mask_left[sel] = 1'b0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_mode)
						MODE_WRITE:             state_d = ST_WRITE;
						MODE_CLEAR, MODE_INVAL: state_d = ST_CLEAR;
						MODE_SCAN:              state_d = stale_eff ? ST_PREP : ST_READ;
						default:                state_d = ST_IDLE;
					endcase
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			ST_PREP:  state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) state_d = ST_READ;
			end
			ST_READ:  state_d = (mask_c != '0) ? ST_EMIT : ST_IDLE;
			ST_EMIT: begin
				if (mask_left == '0) state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				if (clr_q == POS_W'(CELL_COUNT - 1)) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// store ports and handshake
	always_comb begin
		busy      = (state_q != ST_IDLE);
		rd_addr   = pos_q;
		rd_en     = ((state_q == ST_IDLE) && accept && (in_mode == MODE_SCAN) && !stale_eff)
			|| ((state_q == ST_DIV) && div_done);
		cur_we    = ((state_q == ST_WRITE) && wr_ok) || (state_q == ST_CLEAR);
		cur_waddr = (state_q == ST_CLEAR) ? clr_q : POS_W'(wr_off);
		cur_wdata = (state_q == ST_CLEAR) ? 16'd0 : {wr_glyph_q, wr_attr_q};
		old_we    = (state_q == ST_READ) || ((state_q == ST_CLEAR) && clr_old_q);
		old_waddr = (state_q == ST_CLEAR) ? clr_q : pos_q;
		old_wdata = (state_q == ST_CLEAR) ? 16'd0 : cur_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			clr_old_q     <= 1'b1;
			stale_q       <= 1'b1;
			pos_q         <= '0;
			col_q         <= '0;
			row_q         <= '0;
			cells_q       <= '0;
			last_colour_q <= '0;
			in_run_q      <= 1'b1;
			mask_q        <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept && (in_mode == MODE_CLEAR || in_mode == MODE_INVAL)) begin
						clr_q     <= '0;
						clr_old_q <= (in_mode == MODE_INVAL);
					end
				end
				ST_PREP:  cells_q <= cells_c;
				ST_CLAMP: pos_q <= pos_cl;
				ST_DIV: begin
					if (div_done) begin
						col_q <= rem_nx;
						row_q <= ROW_W'(quo_nx);
					end
				end
				ST_READ: begin
					mask_q        <= mask_c;
					last_colour_q <= (~final_c & changed) ? attr : lc_eff;
					in_run_q      <= final_c ? run_eff : changed;
					if (final_c) begin
						pos_q <= '0;
						col_q <= '0;
						row_q <= '0;
					end else begin
						pos_q <= pos_q + POS_W'(1);
						if (col_inc == w_eff) begin
							col_q <= '0;
							row_q <= row_q + ROW_W'(1);
						end else begin
							col_q <= col_inc;
						end
					end
				end
				ST_EMIT:  mask_q <= mask_left;
				ST_CLEAR: clr_q <= clr_q + POS_W'(1);
				default: ;
			endcase
			if (cfg.upd) begin
				stale_q <= 1'b1;
			end else if (state_q == ST_DIV && div_done) begin
				stale_q <= 1'b0;
			end
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			wr_col_q   <= col;
			wr_row_q   <= row;
			wr_glyph_q <= glyph;
			wr_attr_q  <= attribute;
		end
		if (state_q == ST_CLAMP) begin
			rem_q     <= '0;
			quo_q     <= pos_cl;
			div_cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q     <= rem_nx;
			quo_q     <= quo_nx;
			div_cnt_q <= div_cnt_q + DIV_W'(1);
		end
		if (state_q == ST_READ) begin
			sl_lc_q    <= lc_eff;
			sl_attr_q  <= attr;
			sl_glyph_q <= (cur_rdata[15:8] == 8'd0) ? GLYPH_SPACE : cur_rdata[15:8];
			sl_col_q   <= col_q;
			sl_row_q   <= row_q;
			sl_final_q <= final_c;
			sl_ccmd_q  <= ccmd;
		end
	end

	// one result beat per cycle from the pending slots, lowest first
	always_comb begin
		beat_cmd    = CMD_MOVE;
		beat_col    = '0;
		beat_row    = '0;
		beat_colour = '0;
		beat_glyph  = '0;
		case (sel)
			SLOT_FRAME: begin
				beat_cmd    = CMD_FORE_BACK;
				beat_colour = sl_lc_q;
			end
			SLOT_ROW: begin
				beat_cmd = CMD_MOVE;
				beat_row = sl_row_q[5:0];
			end
			SLOT_SKIP: begin
				if (sl_final_q) begin
					beat_cmd = CMD_REFRESH;
				end else begin
					beat_cmd = CMD_MOVE;
					beat_col = sl_col_q[6:0];
					beat_row = sl_row_q[5:0];
				end
			end
			SLOT_COLOUR: begin
				beat_cmd    = sl_ccmd_q;
				beat_colour = sl_attr_q;
			end
			SLOT_GLYPH: begin
				beat_cmd   = CMD_GLYPH;
				beat_glyph = sl_glyph_q;
			end
			default: beat_cmd = CMD_MOVE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			command_q    <= beat_cmd;
			cursor_col_q <= beat_col;
			cursor_row_q <= beat_row;
			fore_q       <= beat_colour[3:0];
			back_q       <= beat_colour[7:4];
			out_glyph_q  <= beat_glyph;
			last_q       <= (mask_left == '0);
		end
	end

	assign strobe     = strobe_q;
	assign command    = command_q;
	assign cursor_col = cursor_col_q;
	assign cursor_row = cursor_row_q;
	assign fore       = fore_q;
	assign back       = back_q;
	assign out_glyph  = out_glyph_q;
	assign last       = last_q;

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (mask_q == '0))
		else $error("result slots pending while idle");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |-> (state_q == ST_IDLE))
		else $error("final beat shown while sequencer still busy");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(!stale_q && state_q == ST_IDLE) |-> ({1'b0, pos_q} < cells_q))
		else $error("scan position outside frame");

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(!stale_q && state_q == ST_IDLE) |-> (col_q < w_eff))
		else $error("column tracker outside row");

	a_scan_reads_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> $past(rd_en))
		else $error("scan evaluated without a store read");

endmodule

// ===== hdl/text_screen_diff_refresher_top.sv =====
// Top level of the text screen diff refresher.
// Depends on tsdr_pkg, tsdr_cfg, tsdr_ctrl and tsdr_ram.

// Commands are taken when start is high and busy is low. A scan gives 0 to
// 4 result beats; each beat sits on the result ports for one cycle under
// strobe, the final one of an item with last set, and cannot be held off.
// The first scan after reset or after any register write first runs a
// divide of the scan position by the width (prepare, clamp and divide
// states). Clear sweeps the current store and invalidate both stores, one
// cell a cycle. After reset the block runs the same sweep over both stores
// and holds busy high until it ends; register writes are taken at any time.
// Scans are a read-modify-write of the two cell memories, each with one read
// port and one write port used at most once per cycle.
module text_screen_diff_refresher_top #(
	parameter int CELL_COUNT = 8192
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [6:0]                   col,
	input  logic [5:0]                   row,
	input  logic [7:0]                   glyph,
	input  logic [7:0]                   attribute,
	output logic                         strobe,
	output logic [2:0]                   command,
	output logic [6:0]                   cursor_col,
	output logic [5:0]                   cursor_row,
	output logic [3:0]                   fore,
	output logic [3:0]                   back,
	output logic [7:0]                   out_glyph,
	output logic                         last,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tsdr_pkg::PADDR_W-1:0] paddr,
	input  logic [tsdr_pkg::PDATA_W-1:0] pwdata,
	output logic [tsdr_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	import tsdr_pkg::*;

	localparam int POS_W = $clog2(CELL_COUNT);

	cfg_t             cfg;
	logic             cur_we;
	logic [POS_W-1:0] cur_waddr;
	logic [15:0]      cur_wdata;
	logic             old_we;
	logic [POS_W-1:0] old_waddr;
	logic [15:0]      old_wdata;
	logic             rd_en;
	logic [POS_W-1:0] rd_addr;
	logic [15:0]      cur_rdata;
	logic [15:0]      old_rdata;

	tsdr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// glyph in [15:8], attribute in [7:0]
	tsdr_ram #(.DEPTH(CELL_COUNT), .DATA_W(16)) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (cur_rdata)
	);

	tsdr_ram #(.DEPTH(CELL_COUNT), .DATA_W(16)) u_old_ram (
		.clk   (clk),
		.we    (old_we),
		.waddr (old_waddr),
		.wdata (old_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (old_rdata)
	);

	tsdr_ctrl #(.CELL_COUNT(CELL_COUNT)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.col        (col),
		.row        (row),
		.glyph      (glyph),
		.attribute  (attribute),
		.cfg        (cfg),
		.cur_we     (cur_we),
		.cur_waddr  (cur_waddr),
		.cur_wdata  (cur_wdata),
		.old_we     (old_we),
		.old_waddr  (old_waddr),
		.old_wdata  (old_wdata),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.cur_rdata  (cur_rdata),
		.old_rdata  (old_rdata),
		.strobe     (strobe),
		.command    (command),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.fore       (fore),
		.back       (back),
		.out_glyph  (out_glyph),
		.last       (last)
	);

endmodule

// ===== tb/sv/text_screen_diff_refresher_top_test.sv =====
// Self-checking testbench for the text screen diff refresher top level.
// Needs tsdr_pkg and text_screen_diff_refresher_top; predicts the terminal command
// stream of every scan and compares it beat by beat.
`timescale 1ns / 100ps

module text_screen_diff_refresher_top_test;
	import tsdr_pkg::*;

	// small cell store keeps clear/invalidate short and makes big screens overflow it
	localparam int CELLS       = 1024;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int IDLE_PAUSE  = 24;

	typedef struct packed {
		mode_t      mode;
		logic [6:0] col;
		logic [5:0] row;
		logic [7:0] glyph;
		logic [7:0] attribute;
	} cell_cmd_t;

	typedef struct packed {
		cmd_t       command;
		logic [6:0] ccol;
		logic [5:0] crow;
		logic [3:0] fore;
		logic [3:0] back;
		logic [7:0] glyph;
		logic       last;
	} term_beat_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [1:0]          mode;
	logic [6:0]          col;
	logic [5:0]          row;
	logic [7:0]          glyph;
	logic [7:0]          attribute;
	logic                strobe;
	logic [2:0]          command;
	logic [6:0]          cursor_col;
	logic [5:0]          cursor_row;
	logic [3:0]          fore;
	logic [3:0]          back;
	logic [7:0]          out_glyph;
	logic                last;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	cell_cmd_t drive_item = '0;

	assign mode      = drive_item.mode;
	assign col       = drive_item.col;
	assign row       = drive_item.row;
	assign glyph     = drive_item.glyph;
	assign attribute = drive_item.attribute;

	text_screen_diff_refresher_top #(.CELL_COUNT(CELLS)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .col(col), .row(row), .glyph(glyph), .attribute(attribute),
		.strobe(strobe), .command(command), .cursor_col(cursor_col),
		.cursor_row(cursor_row), .fore(fore), .back(back), .out_glyph(out_glyph),
		.last(last), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// screen model
	logic [7:0]  cur_glyph [CELLS];
	logic [7:0]  cur_attr  [CELLS];
	logic [7:0]  old_glyph [CELLS];
	logic [7:0]  old_attr  [CELLS];
	logic [7:0]  last_colour;
	bit          in_run;
	int unsigned scan_at;
	logic [7:0]  scr_width;
	logic [6:0]  scr_height;
	bit          ign_bg;

	cell_cmd_t  queued_cmds[$];
	term_beat_t terminal_beats_due[$];

	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned cmds_taken = 0;
	int unsigned beats_seen = 0;
	int unsigned refreshes = 0;
	int unsigned settings_used = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	logic [7:0]  attr_trail = 8'h00;

	function automatic term_beat_t mk_beat(cmd_t k, int unsigned cx, int unsigned ry,
			logic [7:0] colour, logic [7:0] g);
		term_beat_t b;
		b.command = k;
		b.ccol    = 7'(cx);
		b.crow    = 6'(ry);
		b.fore    = colour[3:0];
		b.back    = colour[7:4];
		b.glyph   = g;
		b.last    = 1'b0;
		return b;
	endfunction

	// Applies one accepted command to the model and queues the terminal beats it causes.
	task automatic screen_diff_step(input cell_cmd_t c);
		int unsigned w, h, cells, pos, cx, ry, off;
		logic [7:0]  amask, a_new, a_old, d;
		logic        fd, hd, bd, has_colour;
		cmd_t        ccmd;
		term_beat_t  b;
		term_beat_t  burst[$];
		w = (scr_width == 8'd0) ? 1 : int'(scr_width);
		h = (scr_height == 7'd0) ? 1 : int'(scr_height);
		amask = ign_bg ? MASK_FG : MASK_ALL;
		ccmd = CMD_MOVE;
		case (c.mode)
		MODE_WRITE: begin
			off = c.row * w + c.col;
			if (c.col < w && c.row < h && off < CELLS) begin
				cur_glyph[off] = c.glyph;
				cur_attr[off]  = c.attribute;
			end
		end
		MODE_CLEAR, MODE_INVAL: begin
			for (int i = 0; i < CELLS; i++) begin
				cur_glyph[i] = 8'h00;
				cur_attr[i]  = 8'h00;
				if (c.mode == MODE_INVAL) begin
					old_glyph[i] = 8'h00;
					old_attr[i]  = 8'h00;
				end
			end
		end
		default: begin
			cells = w * h;
			if (cells > CELLS) cells = CELLS;
			// a size change mid-frame can leave the position past the end
			pos = (scan_at >= cells) ? cells - 1 : scan_at;
			cx = pos % w;
			ry = pos / w;
			if (pos == 0) begin
				last_colour = cur_attr[0] & amask;
				in_run = 1'b1;
				burst.push_back(mk_beat(CMD_FORE_BACK, 0, 0, last_colour, 8'h00));
			end
			if (cx == 0) burst.push_back(mk_beat(CMD_MOVE, 0, ry, 8'h00, 8'h00));
			a_new = cur_attr[pos] & amask;
			a_old = old_attr[pos] & amask;
			if (pos == cells - 1) begin
				burst.push_back(mk_beat(CMD_REFRESH, 0, 0, 8'h00, 8'h00));
				scan_at = 0;
			end else begin
				if (cur_glyph[pos] == old_glyph[pos] && a_new == a_old) begin
					in_run = 1'b0;
				end else begin
					if (!in_run) burst.push_back(mk_beat(CMD_MOVE, cx, ry, 8'h00, 8'h00));
					in_run = 1'b1;
					// bit 7 of the colour never takes part in the choice
					d = last_colour ^ a_new;
					fd = |d[2:0];
					hd = d[3];
					bd = |d[6:4];
					has_colour = 1'b1;
					if (hd && !fd) ccmd = a_new[3] ? CMD_HL_BACK : CMD_FORE_BACK;
					else if (hd) ccmd = CMD_FORE_BACK;
					else if (fd && bd) ccmd = CMD_FORE3_BACK;
					else if (fd) ccmd = CMD_FORE3;
					else if (bd) ccmd = CMD_BACK;
					else has_colour = 1'b0;
					if (has_colour) burst.push_back(mk_beat(ccmd, 0, 0, a_new, 8'h00));
					last_colour = a_new;
					burst.push_back(mk_beat(CMD_GLYPH, 0, 0, 8'h00,
						(cur_glyph[pos] == 8'h00) ? GLYPH_SPACE : cur_glyph[pos]));
				end
				scan_at = pos + 1;
			end
			old_glyph[pos] = cur_glyph[pos];
			old_attr[pos]  = cur_attr[pos];
		end
		endcase
		foreach (burst[i]) begin
			b = burst[i];
			b.last = (i == burst.size() - 1);
			terminal_beats_due.push_back(b);
		end
	endtask

	// sender: bursts of commands separated by random gaps
	always @(posedge clk) begin : feeder
		cell_cmd_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				screen_diff_step(drive_item);
				cmds_taken++;
			end
			if (start && busy) begin
				// hold until taken
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (queued_cmds.size() != 0) begin
				nxt = queued_cmds.pop_front();
				drive_item <= nxt;
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
					gap_left <= $urandom_range(1, 7);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("[%0d ns] %s mismatch: expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : watcher
		term_beat_t want;
		if (arst_n && strobe) begin
			beats_seen++;
			if (terminal_beats_due.size() == 0) begin
				$display("[%0d ns] unexpected beat: expected none, actual command %0d",
					$time, command);
				mismatches++;
			end else begin
				want = terminal_beats_due.pop_front();
				check_field("command", want.command, command);
				check_field("cursor_col", want.ccol, cursor_col);
				check_field("cursor_row", want.crow, cursor_row);
				check_field("fore", want.fore, fore);
				check_field("back", want.back, back);
				check_field("out_glyph", want.glyph, out_glyph);
				check_field("last", want.last, last);
				if (want.command == CMD_REFRESH) refreshes++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		REG_WIDTH:  scr_width = val[7:0];
		REG_HEIGHT: scr_height = val[6:0];
		default:    ign_bg = val[0];
		endcase
	endtask

	task automatic set_screen(input int unsigned w, input int unsigned h, input int unsigned ign);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_IGN_BG, ign);
		settings_used++;
	endtask

	// wait until every command is taken, every beat seen and the sweep is over
	task automatic settle();
		while (queued_cmds.size() != 0 || start || terminal_beats_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	function automatic cell_cmd_t mk(mode_t m, logic [6:0] cx, logic [5:0] ry,
			logic [7:0] g, logic [7:0] a);
		cell_cmd_t c;
		c.mode = m;
		c.col = cx;
		c.row = ry;
		c.glyph = g;
		c.attribute = a;
		return c;
	endfunction

	// mostly alter colour fields of the previous attribute so every colour command shows up
	function automatic logic [7:0] next_attr();
		if ($urandom_range(0, 9) < 3) begin
			attr_trail = 8'($urandom_range(0, 255));
		end else begin
			if ($urandom_range(0, 1) != 0) attr_trail[2:0] ^= 3'($urandom_range(1, 7));
			if ($urandom_range(0, 1) != 0) attr_trail[3] ^= 1'b1;
			if ($urandom_range(0, 1) != 0) attr_trail[6:4] ^= 3'($urandom_range(1, 7));
			if ($urandom_range(0, 3) == 0) attr_trail[7] ^= 1'b1;
		end
		return attr_trail;
	endfunction

	task automatic fill_random_phase(input int n);
		int unsigned w, h, cells, idx, roll;
		cell_cmd_t   c;
		w = (scr_width == 8'd0) ? 1 : int'(scr_width);
		h = (scr_height == 7'd0) ? 1 : int'(scr_height);
		cells = (w * h > CELLS) ? CELLS : w * h;
		repeat (n) begin
			c.col = 7'($urandom_range(0, 127));
			c.row = 6'($urandom_range(0, 63));
			c.glyph = 8'($urandom_range(0, 255));
			c.attribute = 8'($urandom_range(0, 255));
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				c.mode = MODE_CLEAR;
			end else if (roll < 8) begin
				c.mode = MODE_INVAL;
			end else if (roll < 14) begin
				c.mode = MODE_WRITE;    // anywhere, mostly off screen
			end else if (roll < 50) begin
				// favor the first 48 cells of the frame
				if ($urandom_range(0, 9) < 7)
					idx = $urandom_range(0, ((cells < 48) ? cells : 48) - 1);
				else
					idx = $urandom_range(0, cells - 1);
				c.mode = MODE_WRITE;
				c.col = 7'(idx % w);
				c.row = 6'(idx / w);
				c.glyph = ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
				c.attribute = next_attr();
			end else begin
				c.mode = MODE_SCAN;
			end
			queued_cmds.push_back(c);
		end
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++) begin
			cur_glyph[i] = 8'h00;
			cur_attr[i]  = 8'h00;
			old_glyph[i] = 8'h00;
			old_attr[i]  = 8'h00;
		end
		last_colour = 8'h00;
		in_run = 1'b1;
		scan_at = 0;
		scr_width = WIDTH_RST;
		scr_height = HEIGHT_RST;
		ign_bg = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// reset size 80x25 overflows the store; off-screen and past-store writes drop
		queued_cmds.push_back(mk(MODE_WRITE, 7'd0, 6'd0, 8'h00, 8'hFF));
		queued_cmds.push_back(mk(MODE_WRITE, 7'd127, 6'd63, 8'hFF, 8'hFF));
		queued_cmds.push_back(mk(MODE_WRITE, 7'd79, 6'd24, 8'hAA, 8'h55));
		queued_cmds.push_back(mk(MODE_WRITE, 7'd1, 6'd0, 8'hFF, 8'h00));
		repeat (3) queued_cmds.push_back(mk(MODE_SCAN, 7'd0, 6'd0, 8'h00, 8'h00));
		queued_cmds.push_back(mk(MODE_CLEAR, 7'd0, 6'd0, 8'h00, 8'h00));
		settle();

		// zero size acts as one cell; the scan position sits past the end
		set_screen(0, 0, 1);
		queued_cmds.push_back(mk(MODE_WRITE, 7'd1, 6'd0, 8'h33, 8'h44));
		queued_cmds.push_back(mk(MODE_WRITE, 7'd0, 6'd0, 8'h41, 8'hF3));
		repeat (2) queued_cmds.push_back(mk(MODE_SCAN, 7'd0, 6'd0, 8'h00, 8'h00));
		settle();

		// 4x2 frame walking the colour choices, a skipped cell and a row start
		set_screen(4, 2, 0);
		queued_cmds.push_back(mk(MODE_INVAL, 7'd0, 6'd0, 8'h00, 8'h00));
		queued_cmds.push_back(mk(MODE_WRITE, 7'd0, 6'd0, 8'h48, 8'h00));
		queued_cmds.push_back(mk(MODE_WRITE, 7'd1, 6'd0, 8'h00, 8'h01));
		queued_cmds.push_back(mk(MODE_WRITE, 7'd2, 6'd0, 8'h7E, 8'h09));
		queued_cmds.push_back(mk(MODE_WRITE, 7'd3, 6'd0, 8'h20, 8'h01));
		queued_cmds.push_back(mk(MODE_WRITE, 7'd1, 6'd1, 8'h5A, 8'h11));
		queued_cmds.push_back(mk(MODE_WRITE, 7'd2, 6'd1, 8'h61, 8'h22));
		repeat (8) queued_cmds.push_back(mk(MODE_SCAN, 7'd0, 6'd0, 8'h00, 8'h00));
		settle();

		for (int p = 0; p < 8; p++) begin
			case (p)
			0:       set_screen(128, 64, 1);
			1:       set_screen(1, 64, 0);
			2:       set_screen(128, 1, $urandom_range(0, 1));
			default: set_screen($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(0, 1));
			endcase
			fill_random_phase(23);
			settle();
		end

		$display("Ran %0d commands over %0d screen settings; checked %0d terminal beats",
			cmds_taken, settings_used, beats_seen);
		$display("including %0d frame refreshes, store clears and oversized/zero-size screens.",
			refreshes);
		if (mismatches == 0 && terminal_beats_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/tsdr_pkg.sv
hdl/tsdr_ram.sv
hdl/tsdr_cfg.sv
hdl/tsdr_ctrl.sv
hdl/text_screen_diff_refresher_top.sv
tb/sv/text_screen_diff_refresher_top_test.sv
